// ----- src/rc4_pkg.sv -----
// ----------------------------------------------------------------------------
// RC4 package
// Shared types, constants and the controller-to-datapath interface.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int TABLE_SIZE  = 256;
  localparam int IDX_W       = 8;
  localparam int KEY_MAX_DEF = 256;

  localparam logic FUNC_KEY  = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] byte_in;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] data_out;
    logic             last_out;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GEN_J,
    ST_GEN_SWAP,
    ST_GEN_KS,
    ST_GEN_OUT,
    ST_KSA_N,
    ST_KSA_J,
    ST_KSA_WJ,
    ST_KSA_WN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic key_wr;
    logic ksa_start;
    logic ksa_rd_n;
    logic ksa_rd_j;
    logic ksa_wr_j;
    logic ksa_wr_n;
    logic ksa_done;
    logic gen_start;
    logic gen_rd_j;
    logic gen_wr_i;
    logic gen_wr_j;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic step_last;
    logic out_free;
  } sts_t;

endpackage

// ----- src/rc4_ctrl.sv -----
// ----------------------------------------------------------------------------
// RC4 controller
// Sequences key loading, key scheduling and keystream generation.
// ----------------------------------------------------------------------------
module rc4_ctrl
  import rc4_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  logic   in_func,
  input  logic   in_last,
  output logic   in_stall,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    logic open_slot;
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    open_slot = 1'b0;

    case (state_r)
      ST_IDLE: begin
        open_slot = 1'b1;
      end
      ST_GEN_OUT: begin
        // The finished byte must land in the output register before the
        // next item can be taken.
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          open_slot    = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_GEN_J: begin
        cmd.gen_rd_j = 1'b1;
        state_nxt    = ST_GEN_SWAP;
      end
      ST_GEN_SWAP: begin
        cmd.gen_wr_i = 1'b1;
        state_nxt    = ST_GEN_KS;
      end
      ST_GEN_KS: begin
        cmd.gen_wr_j = 1'b1;
        state_nxt    = ST_GEN_OUT;
      end
      ST_KSA_N: begin
        cmd.ksa_rd_n = 1'b1;
        state_nxt    = ST_KSA_J;
      end
      ST_KSA_J: begin
        cmd.ksa_rd_j = 1'b1;
        state_nxt    = ST_KSA_WJ;
      end
      ST_KSA_WJ: begin
        cmd.ksa_wr_j = 1'b1;
        state_nxt    = ST_KSA_WN;
      end
      ST_KSA_WN: begin
        cmd.ksa_wr_n = 1'b1;
        if (sts.step_last) begin
          cmd.ksa_done = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_KSA_J;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (open_slot) begin
      in_stall = 1'b0;
      if (in_valid) begin
        if (in_func == FUNC_DATA) begin
          cmd.gen_start = 1'b1;
          state_nxt     = ST_GEN_J;
        end else begin
          cmd.key_wr = 1'b1;
          if (in_last) begin
            cmd.ksa_start = 1'b1;
            state_nxt     = ST_KSA_N;
          end
        end
      end
    end
  end

  a_accept_when_open: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> (state_r == ST_IDLE || state_r == ST_GEN_OUT))
    else $error("item transfer outside an accepting state");

  a_done_on_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ksa_done |-> (sts.step_last && cmd.ksa_wr_n))
    else $error("key schedule finished before the last step");

endmodule

// ----- src/rc4_dp.sv -----
// ----------------------------------------------------------------------------
// RC4 datapath
// Permutation table, key store, indices and the output register.
// ----------------------------------------------------------------------------
module rc4_dp
  import rc4_pkg::*;
#(
  parameter int KEY_MAX = KEY_MAX_DEF
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  cmd_t       cmd,
  output sts_t       sts,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  localparam int CNT_W  = $clog2(KEY_MAX + 1);
  localparam int KIDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int CMP_W  = KIDX_W + 1;

  // Permutation table. An entry whose flag is clear reads as its own index,
  // which gives the identity fill by clearing the flags.
  logic [IDX_W-1:0]      perm_mem_r [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] vld_r;
  logic [IDX_W-1:0]      rd_mem_r;
  logic                  rd_vld_r;
  logic [IDX_W-1:0]      rd_addr_r;
  logic                  fwd_r;
  logic [IDX_W-1:0]      fwd_data_r;

  logic [IDX_W-1:0]      key_mem_r [KEY_MAX];
  logic [IDX_W-1:0]      key_q_r;

  logic [IDX_W-1:0]  idx_i_r,     idx_i_nxt;
  logic [IDX_W-1:0]  idx_j_r,     idx_j_nxt;
  logic [IDX_W-1:0]  step_r,      step_nxt;
  logic [KIDX_W-1:0] kidx_r,      kidx_nxt;
  logic [CNT_W-1:0]  key_count_r, key_count_nxt;
  logic [IDX_W-1:0]  si_r,        si_nxt;
  logic [IDX_W-1:0]  byte_r,      byte_nxt;
  logic              last_r,      last_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r,  out_data_nxt;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  wr_data;
  logic              key_wr_en;
  logic              key_rd_en;
  logic [IDX_W-1:0]  rd_val;
  logic [IDX_W-1:0]  kb;
  logic [IDX_W-1:0]  j_sum;
  logic [CMP_W-1:0]  kidx_inc;

  always_comb begin
    rd_val   = fwd_r ? fwd_data_r : (rd_vld_r ? rd_mem_r : rd_addr_r);
    kb       = (key_count_r == '0) ? '0 : key_q_r;
    kidx_inc = {1'b0, kidx_r} + CMP_W'(1);
    j_sum    = '0;

    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    key_wr_en = 1'b0;
    key_rd_en = 1'b0;

    idx_i_nxt     = idx_i_r;
    idx_j_nxt     = idx_j_r;
    step_nxt      = step_r;
    kidx_nxt      = kidx_r;
    key_count_nxt = key_count_r;
    si_nxt        = si_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (cmd.key_wr && (key_count_r < CNT_W'(KEY_MAX))) begin
      key_wr_en     = 1'b1;
      key_count_nxt = key_count_r + CNT_W'(1);
    end
    if (cmd.ksa_start) begin
      idx_j_nxt = '0;
      step_nxt  = '0;
      kidx_nxt  = '0;
    end
    if (cmd.ksa_rd_n) begin
      rd_en     = 1'b1;
      rd_addr   = step_r;
      key_rd_en = 1'b1;
    end
    if (cmd.ksa_rd_j) begin
      j_sum     = idx_j_r + rd_val + kb;
      idx_j_nxt = j_sum;
      si_nxt    = rd_val;
      rd_en     = 1'b1;
      rd_addr   = j_sum;
      // The key is used cyclically over the bytes that were stored.
      if (key_count_r == '0 || kidx_inc == CMP_W'(key_count_r)) begin
        kidx_nxt = '0;
      end else begin
        kidx_nxt = kidx_inc[KIDX_W-1:0];
      end
    end
    if (cmd.ksa_wr_j) begin
      wr_en   = 1'b1;
      wr_addr = idx_j_r;
      wr_data = si_r;
    end
    if (cmd.ksa_wr_n) begin
      wr_en     = 1'b1;
      wr_addr   = step_r;
      wr_data   = rd_val;
      step_nxt  = step_r + IDX_W'(1);
      rd_en     = 1'b1;
      rd_addr   = step_r + IDX_W'(1);
      key_rd_en = 1'b1;
    end
    if (cmd.ksa_done) begin
      idx_i_nxt     = '0;
      idx_j_nxt     = '0;
      key_count_nxt = '0;
    end
    if (cmd.gen_start) begin
      idx_i_nxt = idx_i_r + IDX_W'(1);
      rd_en     = 1'b1;
      rd_addr   = idx_i_r + IDX_W'(1);
      byte_nxt  = in_data.byte_in;
      last_nxt  = in_data.last;
    end
    if (cmd.gen_rd_j) begin
      j_sum     = idx_j_r + rd_val;
      idx_j_nxt = j_sum;
      si_nxt    = rd_val;
      rd_en     = 1'b1;
      rd_addr   = j_sum;
    end
    if (cmd.gen_wr_i) begin
      wr_en   = 1'b1;
      wr_addr = idx_i_r;
      wr_data = rd_val;
    end
    if (cmd.gen_wr_j) begin
      // Keystream index is the sum of the two swapped entries; the read
      // may hit the entry written in this cycle, which is forwarded.
      wr_en   = 1'b1;
      wr_addr = idx_j_r;
      wr_data = si_r;
      rd_en   = 1'b1;
      rd_addr = si_r + rd_val;
    end
    if (cmd.out_load) begin
      out_data_nxt.data_out = byte_r ^ rd_val;
      out_data_nxt.last_out = last_r;
      out_valid_nxt         = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      perm_mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_mem_r   <= perm_mem_r[rd_addr];
      rd_vld_r   <= vld_r[rd_addr];
      rd_addr_r  <= rd_addr;
      fwd_r      <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.ksa_start) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (key_wr_en) begin
      key_mem_r[key_count_r[KIDX_W-1:0]] <= in_data.byte_in;
    end
    if (key_rd_en) begin
      key_q_r <= key_mem_r[kidx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_i_r     <= '0;
      idx_j_r     <= '0;
      step_r      <= '0;
      kidx_r      <= '0;
      key_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_i_r     <= idx_i_nxt;
      idx_j_r     <= idx_j_nxt;
      step_r      <= step_nxt;
      kidx_r      <= kidx_nxt;
      key_count_r <= key_count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    si_r       <= si_nxt;
    byte_r     <= byte_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign sts.step_last = (step_r == '1);
  assign sts.out_free  = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  a_key_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    key_count_r <= CNT_W'(KEY_MAX))
    else $error("key count beyond the key store");

  a_fwd_only_ks: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en && (rd_addr == wr_addr)) |-> cmd.gen_wr_j)
    else $error("table read and write collide outside the keystream read");

  a_schedule_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ksa_done |=> (idx_i_r == '0 && idx_j_r == '0 && key_count_r == '0))
    else $error("indices not cleared after key scheduling");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("pending result overwritten");

endmodule

// ----- src/rc4_stream_cipher.sv -----
// Data byte: after its transfer, the read, swap and keystream read share the
// single read and write port of the permutation table; the result is loaded
// into the output register once it is free; the next item is taken with it.
// Key byte: stored when taken; the last key byte also starts key scheduling.
// Reset is synchronous, active low; the table reads as identity at once.
// ----------------------------------------------------------------------------
// RC4 stream cipher
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
module rc4_stream_cipher
  import rc4_pkg::*;
#(
  parameter int KEY_MAX = KEY_MAX_DEF
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  cmd_t cmd;
  sts_t sts;

  rc4_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_last  (in_data.last),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rc4_dp #(
    .KEY_MAX (KEY_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
